@@ rtl/bss_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared constants, payload and control types, and the falloff stamp ROM.
package bss_pkg;

  // Buffer and stamp geometry
  localparam int COLS        = 64;
  localparam int ROWS        = 128;
  localparam int STAMP       = 16;
  localparam int COL_W       = $clog2(COLS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int DEPTH       = ROWS * COLS;
  localparam int STAMP_W     = $clog2(STAMP);
  localparam int STAMP_CELLS = STAMP * STAMP;

  // Field and datapath widths
  localparam int VAL_W   = 24;
  localparam int AMT_W   = 17;
  localparam int FRAC_W  = 8;
  localparam int POS_W   = 16;
  localparam int POW_W   = 16;
  localparam int ENT_W   = 16;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int SCALE_W = ENT_W + POW_W;
  localparam int PROD_W  = SCALE_W + AMT_W;
  localparam int CRD_W   = 10;
  localparam int CU_W    = 7;
  localparam int RU_W    = 8;
  localparam int KIND_W  = 2;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [VAL_W-1:0] VALUE_MAX  = {VAL_W{1'b1}};
  localparam longint unsigned  HEIGHT_Q16 = 62259;
  localparam longint unsigned  M2         = 2 * STAMP * STAMP;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SPLAT = 2'd1,
    KIND_READ  = 2'd2
  } req_kind_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SETUP,
    ST_SPLAT,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [KIND_W-1:0]       req_type;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [POW_W-1:0]        power;
    logic [ROW_W-1:0]        read_row;
    logic [COL_W-1:0]        read_col;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [KIND_W-1:0] done_kind;
  } res_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic issue;
    logic sweep;
    logic rd_req;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic empty;
    logic issue_last;
    logic pipe_busy;
  } dp_status_t;

  typedef logic [STAMP_CELLS-1:0][ENT_W-1:0] stamp_rom_t;

  // Integer square root, evaluated only at elaboration.
  function automatic logic [63:0] isqrt(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    n     = n_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > n) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != '0) begin
        if (n >= res + bit_v) begin
          n   = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Radial falloff: (0.95 * (1 - d/dmax))^4 in Q0.16, zero outside the circle.
  function automatic stamp_rom_t build_stamp_rom();
    stamp_rom_t  rom;
    int          dx;
    int          dy;
    logic [63:0] d2;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    for (int y = 0; y < STAMP; y++) begin
      for (int x = 0; x < STAMP; x++) begin
        dx = 2 * x - STAMP;
        dy = 2 * y - STAMP;
        d2 = 64'(dx * dx + dy * dy);
        v  = '0;
        if (d2 <= M2) begin
          q = (d2 << 32) / M2;
          r = isqrt(q);
          if (r > 64'd65536) r = 64'd65536;
          v = (HEIGHT_Q16 * (64'd65536 - r)) >> 16;
          v = (v * v) >> 16;
          v = (v * v) >> 16;
        end
        rom[y * STAMP + x] = v[ENT_W-1:0];
      end
    end
    return rom;
  endfunction

  localparam stamp_rom_t STAMP_ROM = build_stamp_rom();

endpackage

@@ rtl/bss_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: request sequencing state machine for the stamp splatter.
module bss_ctrl import bss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KIND_W-1:0] req_type_i,
  input  dp_status_t        status_i,
  output logic              busy_o,
  output ctrl_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        reply_q, reply_d;   // sweep answers a clear request

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
    end
  end

  always_comb begin
    state_d = state_q;
    reply_d = reply_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = reply_q ? ST_FINISH : ST_IDLE;
          reply_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          unique case (req_type_i)
            KIND_CLEAR: begin
              state_d = ST_SWEEP;
              reply_d = 1'b1;
            end
            KIND_SPLAT: state_d = ST_SETUP;
            KIND_READ:  state_d = ST_READ;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_SPLAT;
      end
      ST_SPLAT: begin
        if (status_i.empty) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
          if (status_i.issue_last) state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_FINISH;
      end
      ST_READ: begin
        cmd_o.rd_req = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/bss_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: splat setup, loop counters, access pipeline, buffer memory and result register.
module bss_dpath import bss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  req_t            req_i,
  input  logic [CU_W-1:0] cols_used_i,
  input  logic [RU_W-1:0] rows_used_i,
  input  ctrl_cmd_t       cmd_i,
  output dp_status_t      status_o,
  output logic            done_o,
  output res_t            result_o
);

  localparam logic signed [CRD_W-1:0] ONE_S   = CRD_W'(1);
  localparam logic signed [CRD_W-1:0] TWO_S   = CRD_W'(2);
  localparam logic signed [CRD_W-1:0] STAMP_S = CRD_W'(STAMP);
  localparam logic signed [CRD_W-1:0] ZERO_S  = '0;

  req_t req_q;

  // Splat setup
  logic signed [CRD_W-1:0] ix_s, iy_s, ystart, yend_a, rmax_s, yend;
  logic [FRAC_W-1:0]       fx, fy;
  logic [WGT_W-1:0]        wx0, wx1, wy0, wy1;
  logic [RU_W-1:0]         rmax;
  logic [CU_W-1:0]         cmax;

  logic signed [CRD_W-1:0] ix_q, iy_q;
  logic [CU_W-1:0]         cmax_q;
  logic [STAMP_W-1:0]      ty_last_q;
  logic                    empty_q;
  logic [AMT_W-1:0]        w_q [4];

  // Loop counters
  logic [STAMP_W-1:0] ty_q, tx_q;
  logic [1:0]         k_q;

  // Access pipeline
  logic signed [CRD_W-1:0] row_s, col_s, cmax_s;
  logic                    col_ok;
  logic                    p0_valid_q, p1_valid_q, p2_valid_q, p3_valid_q;
  logic [ADDR_W-1:0]       p0_addr_q, p1_addr_q, p2_addr_q, p3_addr_q;
  logic [1:0]              p0_k_q, p1_k_q;
  logic [ENT_W-1:0]        p0_stamp_q;
  logic [SCALE_W-1:0]      p1_s_q;
  logic [PROD_W-1:0]       prod;
  logic [AMT_W-1:0]        p2_amt_q, p3_amt_q;

  // Buffer memory
  logic [VAL_W-1:0]  accum_mem [DEPTH];
  logic [VAL_W-1:0]  mem_rd_q;
  logic [ADDR_W-1:0] mem_ra, mem_wa;
  logic [VAL_W-1:0]  mem_wd;
  logic              mem_we;
  logic [ADDR_W-1:0] sweep_q;

  // Write-to-read forwarding for back-to-back accesses
  logic              fw_valid_q;
  logic [ADDR_W-1:0] fw_addr_q;
  logic [VAL_W-1:0]  fw_data_q;
  logic [VAL_W-1:0]  old_val;
  logic [VAL_W:0]    sum;
  logic [VAL_W-1:0]  sat_val;

  logic done_q;
  res_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  // ---------------- setup ----------------
  always_comb begin
    ix_s   = $signed({{(CRD_W-FRAC_W){req_q.x_pos[POS_W-1]}}, req_q.x_pos[POS_W-1:FRAC_W]});
    iy_s   = $signed({{(CRD_W-FRAC_W){req_q.y_pos[POS_W-1]}}, req_q.y_pos[POS_W-1:FRAC_W]});
    fx     = req_q.x_pos[FRAC_W-1:0];
    fy     = req_q.y_pos[FRAC_W-1:0];
    wx1    = {1'b0, fx};
    wy1    = {1'b0, fy};
    wx0    = WGT_W'(1 << FRAC_W) - wx1;
    wy0    = WGT_W'(1 << FRAC_W) - wy1;
    rmax   = (rows_used_i >= RU_W'(ROWS)) ? RU_W'(ROWS) : rows_used_i;
    cmax   = (cols_used_i >= CU_W'(COLS)) ? CU_W'(COLS) : cols_used_i;
    ystart = (iy_s < ONE_S) ? ONE_S : iy_s;
    yend_a = iy_s + STAMP_S;
    rmax_s = $signed({{(CRD_W-RU_W){1'b0}}, rmax}) - TWO_S;
    yend   = (yend_a < rmax_s) ? yend_a : rmax_s;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      ix_q      <= ix_s;
      iy_q      <= iy_s;
      cmax_q    <= cmax;
      empty_q   <= (ystart >= yend);
      ty_last_q <= STAMP_W'(yend - ONE_S - iy_s);
      w_q[0]    <= AMT_W'(wy0 * wx0);
      w_q[1]    <= AMT_W'(wy0 * wx1);
      w_q[2]    <= AMT_W'(wy1 * wx0);
      w_q[3]    <= AMT_W'(wy1 * wx1);
    end
  end

  // ---------------- loop counters ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ty_q <= '0;
      tx_q <= '0;
      k_q  <= '0;
    end else if (cmd_i.setup) begin
      ty_q <= STAMP_W'(ystart - iy_s);
      tx_q <= '0;
      k_q  <= '0;
    end else if (cmd_i.issue) begin
      k_q <= k_q + 2'd1;
      if (k_q == 2'd3) begin
        tx_q <= tx_q + STAMP_W'(1);
        if (tx_q == STAMP_W'(STAMP - 1)) ty_q <= ty_q + STAMP_W'(1);
      end
    end
  end

  // ---------------- stage 0: address, clip, ROM ----------------
  always_comb begin
    row_s  = iy_q + $signed({{(CRD_W-STAMP_W){1'b0}}, ty_q})
                  + $signed({{(CRD_W-1){1'b0}}, k_q[1]});
    col_s  = ix_q + $signed({{(CRD_W-STAMP_W){1'b0}}, tx_q})
                  + $signed({{(CRD_W-1){1'b0}}, k_q[0]});
    cmax_s = $signed({{(CRD_W-CU_W){1'b0}}, cmax_q});
    col_ok = (col_s >= ZERO_S) && (col_s < cmax_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_valid_q <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else begin
      p0_valid_q <= cmd_i.issue && col_ok;
      p1_valid_q <= p0_valid_q;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
    end
  end

  assign prod = p1_s_q * w_q[p1_k_q];

  always_ff @(posedge clk_i) begin
    p0_addr_q  <= {row_s[ROW_W-1:0], col_s[COL_W-1:0]};
    p0_k_q     <= k_q;
    p0_stamp_q <= STAMP_ROM[{ty_q, tx_q}];
    // stage 1: stamp scaled by power
    p1_addr_q  <= p0_addr_q;
    p1_k_q     <= p0_k_q;
    p1_s_q     <= p0_stamp_q * req_q.power;
    // stage 2: bilinear weight, memory read issued
    p2_addr_q  <= p1_addr_q;
    p2_amt_q   <= prod[PROD_W-1:SCALE_W];
    // stage 3: saturating add and write back
    p3_addr_q  <= p2_addr_q;
    p3_amt_q   <= p2_amt_q;
  end

  // ---------------- buffer memory ----------------
  always_comb begin
    old_val = (fw_valid_q && (fw_addr_q == p3_addr_q)) ? fw_data_q : mem_rd_q;
    sum     = {1'b0, old_val} + (VAL_W+1)'(p3_amt_q);
    sat_val = sum[VAL_W] ? VALUE_MAX : sum[VAL_W-1:0];
    mem_ra  = cmd_i.rd_req ? {req_q.read_row, req_q.read_col} : p2_addr_q;
    if (cmd_i.sweep) begin
      mem_we = 1'b1;
      mem_wa = sweep_q;
      mem_wd = '0;
    end else begin
      mem_we = p3_valid_q;
      mem_wa = p3_addr_q;
      mem_wd = sat_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) accum_mem[mem_wa] <= mem_wd;
    mem_rd_q <= accum_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= '0;
      fw_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sweep) sweep_q <= sweep_q + ADDR_W'(1);
      fw_valid_q <= p3_valid_q && !cmd_i.sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_addr_q <= p3_addr_q;
    fw_data_q <= sat_val;
  end

  // ---------------- result ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= cmd_i.finish;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.value     <= (req_q.req_type == KIND_READ) ? mem_rd_q : '0;
      res_q.done_kind <= req_q.req_type;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  assign status_o.sweep_last = &sweep_q;
  assign status_o.empty      = empty_q;
  assign status_o.issue_last = (k_q == 2'd3) && (tx_q == STAMP_W'(STAMP - 1))
                               && (ty_q == ty_last_q);
  assign status_o.pipe_busy  = p0_valid_q | p1_valid_q | p2_valid_q | p3_valid_q;

endmodule

@@ rtl/bilinear_stamp_splatter_unit.sv @@
`timescale 1ns / 1ps
// Top level: bilinear stamp splatter with APB configuration registers.
//
//  channel   | handshake              | payload            | notes
//  ----------+------------------------+--------------------+---------------------------
//  request   | start in, busy out     | req_i (req_t)      | taken when start && !busy
//  result    | done_o strobe          | result_o (res_t)   | one cycle, cannot stall
//  config    | psel/penable/pwrite    | paddr, pwdata      | pready tied high, reads ok
//
//  A clear sweeps the buffer at one entry per cycle. A splat visits every column of
//  each clipped stamp row, up to 16 rows for a full stamp, and no cell when no stamp
//  row is in range. The splat rate is set by the single write port of the buffer
//  memory: one read-modify-write of one entry per cycle, four per stamp cell.
//  After reset the block sweeps zeros through all 8192 entries with busy high before
//  the first request is taken; config writes work throughout.
//  The result strobe is registered; the next request may start in its cycle.
module bilinear_stamp_splatter_unit import bss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  // result
  output logic              done_o,
  output res_t              result_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // register select is the word address bit
  localparam logic REG_COLS_USED = 1'b0;
  localparam logic REG_ROWS_USED = 1'b1;

  logic [CU_W-1:0] cols_used_q;
  logic [RU_W-1:0] rows_used_q;
  logic            cfg_wr;
  ctrl_cmd_t       cmd;
  dp_status_t      status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_used_q <= CU_W'(42);
      rows_used_q <= RU_W'(70);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COLS_USED: cols_used_q <= pwdata[CU_W-1:0];
        REG_ROWS_USED: rows_used_q <= pwdata[RU_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLS_USED: prdata = APB_DW'(cols_used_q);
      REG_ROWS_USED: prdata = APB_DW'(rows_used_q);
      default:       prdata = '0;
    endcase
  end

  // sequencing
  bss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .status_i   (status),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  // buffer, stamp pipeline and result register
  bss_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cols_used_i (cols_used_q),
    .rows_used_i (rows_used_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

@@ rtl/bss_checker.sv @@
`timescale 1ns / 1ps
// Checker: port-level assertions for the stamp splatter, bound to the top level.
module bss_checker import bss_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t result_o
);

  // a taken request raises busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // the result strobe is never high back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // a result closes a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result without a preceding busy period");

  // only reads carry data
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.done_kind != KIND_READ)) |-> (result_o.value == '0))
    else $error("nonzero value on a non-read result");

endmodule

bind bilinear_stamp_splatter_unit bss_checker u_bss_checker (.*);
